// ===== design/bsa_pkg.sv =====
package bsa_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int WORD_W        = 32;
  localparam int FUNC_W        = 2;
  localparam int IDX_W         = 10;
  localparam int STAT_W        = 2;
  localparam int CFG_W         = 11;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 11'd1024;

  localparam logic REG_SLOTS_IN_USE = 1'b0;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_TAKEN = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_init;
    logic clear_step;
    logic eval;
  } ctl_cmd_t;

  typedef struct packed {
    logic imm_done;
    logic eval_done;
    logic clear_last;
  } dp_stat_t;

endpackage

// ===== design/bsa_ram.sv =====
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bsa_dp.sv =====
module bsa_dp #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bsa_pkg::ctl_cmd_t           cmd,
  output bsa_pkg::dp_stat_t           stat,
  input  logic [bsa_pkg::FUNC_W-1:0]  func,
  input  logic [bsa_pkg::IDX_W-1:0]   slot_index,
  input  logic [bsa_pkg::CFG_W-1:0]   slots_in_use,
  output logic [bsa_pkg::IDX_W-1:0]   result_index,
  output logic [bsa_pkg::STAT_W-1:0]  status
);
  import bsa_pkg::*;

  localparam int WORDS   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int POS_W   = WADDR_W + BIT_W;
  localparam int LIM_W   = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;

  logic [LIM_W-1:0]   cfg_wide;
  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   idx_wide;
  logic [WADDR_W-1:0] idx_word;
  logic               alloc_in;

  logic [FUNC_W-1:0]  func_q;
  logic [IDX_W-1:0]   idx_q;
  logic [WADDR_W-1:0] scan_addr;
  logic [WADDR_W-1:0] clr_cnt;

  logic [LIM_W-1:0]   base;
  logic [LIM_W-1:0]   rem;
  logic               last_word;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  free_bits;
  logic [BIT_W-1:0]   pos;
  logic               found;
  logic [LIM_W-1:0]   pos_wide;
  logic               alloc_q;
  logic               bit_sel;
  logic               eval_wr;
  logic [WORD_W-1:0]  new_word;

  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  assign cfg_wide = LIM_W'(slots_in_use);
  assign limit    = (cfg_wide > LIM_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS) : cfg_wide;
  assign idx_wide = LIM_W'(slot_index);
  assign idx_word = idx_wide[BIT_W +: WADDR_W];
  assign alloc_in = (func == FN_ALLOC);

  assign stat.imm_done   = alloc_in ? (limit == '0) : (idx_wide >= limit);
  assign stat.clear_last = (clr_cnt == WADDR_W'(WORDS - 1));

  // valid bits of the current word under the slot limit
  assign base      = LIM_W'({scan_addr, {BIT_W{1'b0}}});
  assign rem       = limit - base;
  assign last_word = (rem <= LIM_W'(WORD_W));
  assign mask      = (rem >= LIM_W'(WORD_W)) ? '1
                   : ((WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1));
  assign free_bits = ~ram_rdata & mask;
  assign found     = |free_bits;

  always_comb begin
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pos = BIT_W'(b);
      end
    end
  end

  assign pos_wide = LIM_W'({scan_addr, pos});
  assign alloc_q  = (func_q == FN_ALLOC);
  assign bit_sel  = ram_rdata[idx_q[BIT_W-1:0]];

  assign stat.eval_done = alloc_q ? (found | last_word) : 1'b1;
  assign eval_wr  = alloc_q ? found : ((func_q == FN_FREE) && bit_sel);
  assign new_word = alloc_q ? (ram_rdata | (WORD_W'(1) << pos))
                  : (ram_rdata & ~(WORD_W'(1) << idx_q[BIT_W-1:0]));

  assign ram_we    = cmd.clear_step | (cmd.eval & eval_wr);
  assign ram_waddr = cmd.clear_step ? clr_cnt : scan_addr;
  assign ram_wdata = cmd.clear_step ? '0 : new_word;
  assign ram_raddr = cmd.accept ? (alloc_in ? '0 : idx_word)
                   : WADDR_W'(scan_addr + 1'b1);

  bsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_init) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= WADDR_W'(clr_cnt + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q    <= func;
      idx_q     <= slot_index;
      scan_addr <= alloc_in ? '0 : idx_word;
      if (stat.imm_done) begin
        result_index <= alloc_in ? '0 : slot_index;
        status       <= alloc_in ? ST_FULL : ST_RANGE;
      end
    end else if (cmd.eval) begin
      if (!stat.eval_done) begin
        scan_addr <= WADDR_W'(scan_addr + 1'b1);
      end else if (alloc_q) begin
        result_index <= found ? pos_wide[IDX_W-1:0] : '0;
        status       <= found ? ST_OK : ST_FULL;
      end else begin
        result_index <= idx_q;
        status       <= bit_sel ? ST_OK : ST_NOT_TAKEN;
      end
    end
  end

endmodule

// ===== design/bsa_ctrl.sv =====
module bsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cfg_wr,
  input  bsa_pkg::dp_stat_t stat,
  output bsa_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import bsa_pkg::*;

  state_t state;
  state_t state_next;
  logic   done_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    done_next  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (!cfg_wr) begin
          cmd.clear_step = 1'b1;
          if (stat.clear_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.imm_done) begin
            done_next = 1'b1;
          end else begin
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.eval_done) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (cfg_wr) begin
      cmd.clear_init = 1'b1;
      state_next     = S_CLEAR;
      done_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== design/bitmap_slot_allocator_top.sv =====
// first-fit slot allocator over an occupancy bitmap held in a word-wide ram
// request channel: func and slot_index are taken at a clock edge with start
// high and busy low; func selects allocate, free or query
// result channel: result_index and status appear for exactly one cycle with
// done high; the receiver cannot stall, so nothing is held back
// free, query: one eval state reads the ram word that holds slot_index
// allocate: 32-bit bitmap words are scanned in order from word 0, stopping at the
// first word with a free bit or at the last word under min(slots_in_use, MAX_SLOTS)
// out-of-range index, or allocate with no managed slot: done without a ram read
// a new request is taken in the same cycle that done is shown
// apb port: register slots_in_use at byte address 0, reset 1024; a write
// starts a clearing pass over the bitmap
// reset and every slots_in_use write clear the bitmap, one ram word per cycle
// while no new write comes, ceil(MAX_SLOTS / 32) words (32 by default), busy high
module bitmap_slot_allocator_top #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bsa_pkg::FUNC_W-1:0]      func,
  input  logic [bsa_pkg::IDX_W-1:0]       slot_index,
  output logic                            done,
  output logic [bsa_pkg::IDX_W-1:0]       result_index,
  output logic [bsa_pkg::STAT_W-1:0]      status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsa_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bsa_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bsa_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import bsa_pkg::*;

  logic             cfg_wr;
  logic [CFG_W-1:0] slots_in_use;
  ctl_cmd_t         cmd;
  dp_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SLOTS_IN_USE);
  assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? APB_DATA_W'(slots_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_wr) begin
      slots_in_use <= pwdata[CFG_W-1:0];
    end
  end

  bsa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_wr (cfg_wr),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bsa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .slot_index   (slot_index),
    .slots_in_use (slots_in_use),
    .result_index (result_index),
    .status       (status)
  );

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result without a request in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (result_index == '0))
    else $error("pool full with nonzero index");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy)
    else $error("no clearing pass after slot count write");

endmodule
